[src/sfcd_pkg.sv]
// Shared constants and types for the serial bus frame channel decoder.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam int unsigned FRAME_LEN  = 25;
  localparam int unsigned KEPT_BYTES = 10;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CHAN_W     = 11;
  localparam int unsigned IDX_W      = 3;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h0F;

  // Frame byte counts at which each channel is complete
  localparam logic [POS_W-1:0] POS_CH0 = 5'd3;
  localparam logic [POS_W-1:0] POS_CH1 = 5'd4;
  localparam logic [POS_W-1:0] POS_CH2 = 5'd6;
  localparam logic [POS_W-1:0] POS_CH3 = 5'd7;
  localparam logic [POS_W-1:0] POS_CH4 = 5'd8;
  localparam logic [POS_W-1:0] POS_CH5 = 5'd10;

  localparam logic [IDX_W-1:0] CH0 = 3'd0;
  localparam logic [IDX_W-1:0] CH1 = 3'd1;
  localparam logic [IDX_W-1:0] CH2 = 3'd2;
  localparam logic [IDX_W-1:0] CH3 = 3'd3;
  localparam logic [IDX_W-1:0] CH4 = 3'd4;
  localparam logic [IDX_W-1:0] CH5 = 3'd5;

  typedef logic [KEPT_BYTES-1:0][BYTE_W-1:0] frame_view_t;

  typedef struct packed {
    logic             fire;       // byte taken into a frame
    logic [POS_W-1:0] pos;        // byte count including this byte
    logic             frame_end;  // this byte closes the frame
  } track_ev_t;

  typedef struct packed {
    logic              valid;
    logic              frame_end;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] value;
  } chan_res_t;

endpackage

[src/sfcd_frame_track.sv]
// Sync detection, frame byte counter and storage of the first ten frame bytes.
`timescale 1ns / 1ps

module sfcd_frame_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sfcd_pkg::BYTE_W-1:0] cfg_wdata,
  input  logic                        step,
  input  logic [sfcd_pkg::BYTE_W-1:0] rx_byte,
  output sfcd_pkg::track_ev_t         ev,
  output sfcd_pkg::frame_view_t       view
);
  import sfcd_pkg::*;

  logic [BYTE_W-1:0] sync_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  pos_inc;
  frame_view_t       bytes_r;
  logic              take;
  logic              at_end;

  assign take    = step && ((pos_r != '0) || (rx_byte == sync_r));
  assign pos_inc = pos_r + POS_W'(1);
  assign at_end  = pos_inc >= POS_W'(FRAME_LEN);

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = at_end ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      pos_r  <= '0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (pos_r < POS_W'(KEPT_BYTES))) begin
      bytes_r[pos_r[3:0]] <= rx_byte;
    end
  end

  // Current byte bypasses storage so a channel completes in the same pass
  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      view[i] = (take && (pos_r == POS_W'(i))) ? rx_byte : bytes_r[i];
    end
  end

  assign ev.fire      = take;
  assign ev.pos       = pos_inc;
  assign ev.frame_end = at_end;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(FRAME_LEN))
    else $error("frame byte count out of range");

  a_idle_needs_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) && step && (rx_byte != sync_r) |=> (pos_r == '0))
    else $error("left idle without sync byte");

endmodule

[src/sfcd_chan_unpack.sv]
// Unpacks the 11-bit channel values and the end-of-frame marker.
`timescale 1ns / 1ps

module sfcd_chan_unpack (
  input  sfcd_pkg::track_ev_t   ev,
  input  sfcd_pkg::frame_view_t view,
  output sfcd_pkg::chan_res_t   res
);
  import sfcd_pkg::*;

  logic [15:0] w12, w23, w56, w67;
  logic [23:0] w345, w789;

  assign w12  = {view[2], view[1]};
  assign w23  = {view[3], view[2]};
  assign w56  = {view[6], view[5]};
  assign w67  = {view[7], view[6]};
  assign w345 = {view[5], view[4], view[3]};
  assign w789 = {view[9], view[8], view[7]};

  always_comb begin
    res.valid     = 1'b0;
    res.frame_end = 1'b0;
    res.idx       = CH0;
    res.value     = '0;
    case (ev.pos)
      POS_CH0: begin
        res.valid = ev.fire;
        res.idx   = CH0;
        res.value = w12[10:0];
      end
      POS_CH1: begin
        res.valid = ev.fire;
        res.idx   = CH1;
        res.value = w23[13:3];
      end
      POS_CH2: begin
        res.valid = ev.fire;
        res.idx   = CH2;
        res.value = w345[16:6];
      end
      POS_CH3: begin
        res.valid = ev.fire;
        res.idx   = CH3;
        res.value = w56[11:1];
      end
      POS_CH4: begin
        res.valid = ev.fire;
        res.idx   = CH4;
        res.value = w67[14:4];
      end
      POS_CH5: begin
        res.valid = ev.fire;
        res.idx   = CH5;
        res.value = w789[17:7];
      end
      default: begin
        res.valid     = ev.fire && ev.frame_end;
        res.frame_end = ev.frame_end;
      end
    endcase
  end

endmodule

[src/sbus_frame_channel_decoder_core.sv]
// Top level of the serial bus frame channel decoder.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one received serial byte per transfer in in_tdata.
//   out_* : one result per transfer. out_tdata[10:0] holds the channel value,
//           out_tuser the channel number 0..5, out_tlast marks end of frame
//           (then value and channel number are zero).
//   cfg_* : cfg_we writes cfg_wdata into the sync byte register (reset 0x0F);
//           write only while the decoder is idle.
// Bytes before a sync byte are dropped. A frame is 25 bytes; channels 0..5
// come out after frame bytes 3, 4, 6, 7, 8 and 10, the end marker after 25.
// Throughput: one byte per cycle while out_tready does not hold the output. A byte goes
// into an input register, then one pass through counter update and unpack logic
// loads the output register, which drives the result on out_tvalid.
// When out_tready is low the output register holds and the input register
// still takes one more byte before in_tready drops.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for sync.

module sbus_frame_channel_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] channel_value, [15:11] zero
  output logic        out_tlast,  // frame_end
  output logic [2:0]  out_tuser,  // [2:0] channel_index
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // sync_byte
);
  import sfcd_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CHAN_W-1:0] out_value_r;
  logic              out_free;
  logic              step;
  logic              in_xfer;
  track_ev_t         ev;
  frame_view_t       view;
  chan_res_t         res;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;
  assign step      = in_valid_r && out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_tdata;
    end
    if (step) begin
      out_last_r  <= res.frame_end;
      out_idx_r   <= res.idx;
      out_value_r <= res.value;
    end
  end

  sfcd_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (in_byte_r),
    .ev        (ev),
    .view      (view)
  );

  sfcd_chan_unpack u_unpack (
    .ev   (ev),
    .view (view),
    .res  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_idx_r;
  assign out_tdata  = {{(16 - CHAN_W){1'b0}}, out_value_r};

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (out_idx_r == '0) && (out_value_r == '0))
    else $error("end marker carries channel data");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r <= CH5))
    else $error("channel number out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

endmodule

[tb/sbus_frame_checker.sv]
// Checker for the frame channel decoder: predicts results from byte transfers and compares.
`timescale 1ns / 1ps

module sbus_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import sfcd_pkg::*;

  logic [BYTE_W-1:0] sync_val;
  logic [POS_W-1:0]  byte_pos;
  logic [BYTE_W-1:0] kept [KEPT_BYTES];
  chan_res_t         channel_queue [$];

  initial begin
    sync_val   = SYNC_RESET;
    byte_pos   = '0;
    fail_count = 0;
    pending    = 0;
    foreach (kept[i]) kept[i] = '0;
  end

  // Advance the frame tracker by one byte; valid is set when the byte yields a result.
  function automatic chan_res_t decode_frame_byte(input logic [BYTE_W-1:0] b);
    chan_res_t   r;
    logic [31:0] w;
    r = '0;
    w = '0;
    if (byte_pos == 0 && b != sync_val) return r;
    if (byte_pos < KEPT_BYTES) kept[byte_pos[3:0]] = b;
    byte_pos = byte_pos + 1'b1;
    r.valid = 1'b1;
    case (byte_pos)
      POS_CH0: begin
        w = kept[1] | (32'(kept[2]) << 8);
        r.idx = CH0;
      end
      POS_CH1: begin
        w = (kept[2] >> 3) | (32'(kept[3]) << 5);
        r.idx = CH1;
      end
      POS_CH2: begin
        w = (kept[3] >> 6) | (32'(kept[4]) << 2) | (32'(kept[5]) << 10);
        r.idx = CH2;
      end
      POS_CH3: begin
        w = (kept[5] >> 1) | (32'(kept[6]) << 7);
        r.idx = CH3;
      end
      POS_CH4: begin
        w = (kept[6] >> 4) | (32'(kept[7]) << 4);
        r.idx = CH4;
      end
      POS_CH5: begin
        w = (kept[7] >> 7) | (32'(kept[8]) << 1) | (32'(kept[9]) << 9);
        r.idx = CH5;
      end
      default: begin
        if (byte_pos >= FRAME_LEN) begin
          byte_pos    = '0;
          r.frame_end = 1'b1;
        end else begin
          r.valid = 1'b0;
        end
      end
    endcase
    r.value = w[CHAN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    chan_res_t r;
    chan_res_t e;
    if (!rst_n) begin
      sync_val = SYNC_RESET;
      byte_pos = '0;
      channel_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (channel_queue.size() == 0) begin
          $display("%0t: unexpected result: last=%b ch=%0d value=%0d",
                   $time, out_tlast, out_tuser, out_tdata);
          fail_count++;
        end else begin
          e = channel_queue.pop_front();
          if (out_tlast !== e.frame_end || out_tuser !== e.idx ||
              out_tdata !== {5'b0, e.value}) begin
            $display("%0t: mismatch: expected last=%b ch=%0d value=%0d, %s",
                     $time, e.frame_end, e.idx, e.value,
                     $sformatf("got last=%b ch=%0d value=%0d",
                               out_tlast, out_tuser, out_tdata));
            fail_count++;
          end
        end
      end
      if (cfg_we) sync_val = cfg_wdata;
      if (in_tvalid && in_tready) begin
        r = decode_frame_byte(in_tdata);
        if (r.valid) channel_queue.push_back(r);
      end
    end
    pending = channel_queue.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top: drives byte stream, sync register and backpressure, and reports the verdict.
`timescale 1ns / 1ps

module testbench;
  import sfcd_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned FRAMES_PER_SEG = 11;
  localparam int unsigned NUM_SEGS       = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  int          fail_count;
  int          pending;
  int unsigned gap_pct      = 32;
  int unsigned stall_pct    = 81;
  int unsigned quiet_cycles = 0;
  logic [7:0]  cur_sync     = SYNC_RESET;

  sbus_frame_channel_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  sbus_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with valid still up.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_sync  = v;
  endtask

  // Sync, then 24 data bytes biased toward all-zero and all-one values.
  task automatic send_frame();
    logic [7:0] d;
    send_byte(cur_sync);
    for (int i = 1; i < FRAME_LEN; i++) begin
      case ($urandom_range(7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom_range(255));
      endcase
      send_byte(d);
    end
  endtask

  // Line noise between frames; mostly non-sync, occasionally a stray sync that misaligns framing.
  task automatic send_noise();
    logic [7:0] v;
    repeat ($urandom_range(3)) begin
      v = 8'($urandom_range(255));
      if ($urandom_range(9) != 0 && v == cur_sync) v = ~v;
      send_byte(v);
    end
  endtask

  initial begin : stimulus
    logic [7:0] sync_plan [NUM_SEGS];
    logic [7:0] d;
    sync_plan = '{8'h00, 8'hFF, 8'h5A, 8'h80, SYNC_RESET, 8'h01};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // bytes dropped while waiting for sync
    send_byte(8'h00);
    send_byte(8'hFF);
    // frame at reset sync: saturated and empty channels, sync value as data past the kept bytes
    send_byte(SYNC_RESET);
    for (int i = 1; i < FRAME_LEN; i++) begin
      if (i < 5) d = 8'hFF;
      else if (i < 10) d = 8'h00;
      else if (i == 10) d = SYNC_RESET;
      else d = 8'hA5 ^ 8'(i);
      send_byte(d);
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin gap_pct = 32; stall_pct = 81; end
        1: begin gap_pct = 81; stall_pct = 32; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      write_sync((seg % 3 == 2) ? 8'($urandom_range(255)) : sync_plan[seg]);
      repeat (FRAMES_PER_SEG) begin
        send_noise();
        send_frame();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/sfcd_pkg.sv
src/sfcd_frame_track.sv
src/sfcd_chan_unpack.sv
src/sbus_frame_channel_decoder_core.sv
tb/sbus_frame_checker.sv
tb/testbench.sv
